@@ rtl/qte_pkg.sv @@
package qte_pkg;

    // Width of the Q2.30 products and sums after doubling
    localparam int VW = 35;
    localparam int ROOT_W = 62;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_PRE = 3;
    localparam int ISQ_LAT = SQRT_PRE + SQRT_STEPS;
    localparam int TERMS_LAT = 2;
    localparam logic signed [VW-1:0] ONE_Q30 = 35'sd1073741824;
    localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;

    typedef logic signed [VW-1:0] vec_t;

    typedef struct packed {
        vec_t sr;
        vec_t cr;
        vec_t sy;
        vec_t cy;
        vec_t sp;
        logic clamp;
        logic clamp_neg;
    } terms_t;

    typedef struct packed {
        logic clamp;
        logic clamp_neg;
    } pflag_t;

    function automatic vec_t sx32(input logic signed [31:0] v);
        return {{(VW-32){v[31]}}, v};
    endfunction

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/qte_terms.sv @@
module qte_terms (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [15:0]   quat_w,
    input  logic signed [15:0]   quat_x,
    input  logic signed [15:0]   quat_y,
    input  logic signed [15:0]   quat_z,
    output logic                 out_valid,
    output qte_pkg::terms_t      terms
);
    import qte_pkg::*;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    logic               v1_reg, v2_reg;
    terms_t             terms_reg, terms_next;

    always_ff @(posedge clk)
    begin
        wx_reg <= quat_w * quat_x;
        yz_reg <= quat_y * quat_z;
        xx_reg <= quat_x * quat_x;
        yy_reg <= quat_y * quat_y;
        wz_reg <= quat_w * quat_z;
        xy_reg <= quat_x * quat_y;
        zz_reg <= quat_z * quat_z;
        wy_reg <= quat_w * quat_y;
        zx_reg <= quat_z * quat_x;
        terms_reg <= terms_next;
    end

    always_comb
    begin
        terms_next.sr = (sx32(wx_reg) + sx32(yz_reg)) <<< 1;
        terms_next.cr = ONE_Q30 - ((sx32(xx_reg) + sx32(yy_reg)) <<< 1);
        terms_next.sy = (sx32(wz_reg) + sx32(xy_reg)) <<< 1;
        terms_next.cy = ONE_Q30 - ((sx32(yy_reg) + sx32(zz_reg)) <<< 1);
        terms_next.sp = (sx32(wy_reg) - sx32(zx_reg)) <<< 1;
        terms_next.clamp_neg = (terms_next.sp <= -ONE_Q30);
        terms_next.clamp = (terms_next.sp >= ONE_Q30) || terms_next.clamp_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign terms = terms_reg;

endmodule

@@ rtl/qte_isqrt.sv @@
module qte_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  qte_pkg::vec_t      sp,
    input  logic               clamp,
    output logic               out_valid,
    output logic [30:0]        root
);
    import qte_pkg::*;

    vec_t                    sp_abs;
    logic [29:0]             mag_reg;
    logic [59:0]             sq_reg;
    logic [ROOT_W-1:0]       v_reg [0:SQRT_STEPS];
    logic [ROOT_W-1:0]       r_reg [0:SQRT_STEPS];
    logic [ISQ_LAT-1:0]      vld_reg;

    assign sp_abs = sp[VW-1] ? -sp : sp;

    always_ff @(posedge clk)
    begin
        mag_reg <= clamp ? '0 : sp_abs[29:0];
        sq_reg <= mag_reg * mag_reg;
        v_reg[0] <= (ROOT_W'(1) << 60) - {2'b00, sq_reg};
        r_reg[0] <= '0;
    end

    // one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (60 - 2 * k);
        logic [ROOT_W-1:0] trial;
        logic [ROOT_W-1:0] v_next, r_next;

        always_comb
        begin
            trial = r_reg[k] + BIT;
            if (v_reg[k] >= trial)
            begin
                v_next = v_reg[k] - trial;
                r_next = (r_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_next = v_reg[k];
                r_next = r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[k+1] <= v_next;
            r_reg[k+1] <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[ISQ_LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[ISQ_LAT-1];
    assign root = r_reg[SQRT_STEPS][30:0];

endmodule

@@ rtl/qte_cordic.sv @@
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  qte_pkg::vec_t      y,
    input  qte_pkg::vec_t      x,
    output logic               out_valid,
    output logic [15:0]        angle
);
    import qte_pkg::*;

    localparam int CW = VW + 2;
    localparam int LAT = STAGES + 2;

    logic signed [CW-1:0] xw, yw;
    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic [31:0]          z_reg [0:STAGES];
    logic                 zero_reg [0:STAGES];
    logic [31:0]          z_round;
    logic [15:0]          angle_reg;
    logic [LAT-1:0]       vld_reg;

    assign xw = {{(CW-VW){x[VW-1]}}, x};
    assign yw = {{(CW-VW){y[VW-1]}}, y};

    // fold the left half plane by a half turn
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (x == '0) && (y == '0);
        x_reg[0] <= x[VW-1] ? -xw : xw;
        y_reg[0] <= x[VW-1] ? -yw : yw;
        z_reg[0] <= x[VW-1] ? 32'h80000000 : 32'h00000000;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        localparam logic [31:0] ATAN = atan_turn(i);
        logic signed [CW-1:0] xs, ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (!y_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
        end
    end

    assign z_round = z_reg[STAGES] + 32'h00008000;

    always_ff @(posedge clk)
    begin
        angle_reg <= zero_reg[STAGES] ? 16'h0000 : z_round[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[LAT-1];
    assign angle = angle_reg;

endmodule

@@ rtl/quaternion_to_euler_top.sv @@
// Channel   Handshake                Payload
// input     start (busy always low)  quat_w, quat_x, quat_y, quat_z
// result    done, one-cycle strobe   roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One transaction per cycle. The path runs through the product registers, the pitch
// square root (one root bit per stage), the three parallel CORDIC pipelines and
// 1 output register.
// rst_n clears only the valid chains; no transaction is in flight after reset.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
module quaternion_to_euler_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [15:0]   quat_w,
    input  logic signed [15:0]   quat_x,
    input  logic signed [15:0]   quat_y,
    input  logic signed [15:0]   quat_z,
    output logic                 done,
    output logic signed [15:0]   roll_angle,
    output logic signed [15:0]   pitch_angle,
    output logic signed [15:0]   yaw_angle,
    output logic                 pitch_clamped
);
    import qte_pkg::*;

    localparam int CLAT = CORDIC_STAGES + 2;
    localparam int TOTAL_LAT = TERMS_LAT + ISQ_LAT + CLAT + 1;

    logic          t_valid, s_valid;
    terms_t        t_terms;
    logic [30:0]   root;
    terms_t        dly_reg [0:ISQ_LAT-1];
    terms_t        t_dly;
    pflag_t        pf_reg [0:CLAT-1];
    pflag_t        pf;
    logic          r_valid, p_valid, y_valid;
    logic [15:0]   roll_a, pitch_a, yaw_a;
    logic signed [15:0] pitch_s, pitch_next;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic          clamp_reg, done_reg;

    assign busy = 1'b0;

    qte_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (t_valid),
        .terms     (t_terms)
    );

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .sp        (t_terms.sp),
        .clamp     (t_terms.clamp),
        .out_valid (s_valid),
        .root      (root)
    );

    // hold the atan2 arguments while the pitch root is formed
    always_ff @(posedge clk)
    begin
        dly_reg[0] <= t_terms;
        for (int i = 1; i < ISQ_LAT; i++)
            dly_reg[i] <= dly_reg[i-1];
    end
    assign t_dly = dly_reg[ISQ_LAT-1];

    always_ff @(posedge clk)
    begin
        pf_reg[0] <= '{clamp: t_dly.clamp, clamp_neg: t_dly.clamp_neg};
        for (int i = 1; i < CLAT; i++)
            pf_reg[i] <= pf_reg[i-1];
    end
    assign pf = pf_reg[CLAT-1];

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .y         (t_dly.sr),
        .x         (t_dly.cr),
        .out_valid (r_valid),
        .angle     (roll_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .y         (t_dly.sp),
        .x         ({{(VW-31){1'b0}}, root}),
        .out_valid (p_valid),
        .angle     (pitch_a)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .y         (t_dly.sy),
        .x         (t_dly.cy),
        .out_valid (y_valid),
        .angle     (yaw_a)
    );

    assign pitch_s = pitch_a;

    always_comb
    begin
        if (pf.clamp)
            pitch_next = pf.clamp_neg ? -QUARTER_TURN : QUARTER_TURN;
        else if (pitch_s > QUARTER_TURN)
            pitch_next = QUARTER_TURN;
        else if (pitch_s < -QUARTER_TURN)
            pitch_next = -QUARTER_TURN;
        else
            pitch_next = pitch_s;
    end

    always_ff @(posedge clk)
    begin
        roll_reg <= roll_a;
        pitch_reg <= pitch_next;
        yaw_reg <= yaw_a;
        clamp_reg <= pf.clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= r_valid & p_valid & y_valid;
    end

    assign done = done_reg;
    assign roll_angle = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle = yaw_reg;
    assign pitch_clamped = clamp_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid == p_valid) && (p_valid == y_valid))
        else $error("angle lanes out of step");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= QUARTER_TURN) && (pitch_angle >= -QUARTER_TURN))
        else $error("pitch out of range");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && pitch_clamped |-> (pitch_angle == QUARTER_TURN) || (pitch_angle == -QUARTER_TURN))
        else $error("clamped pitch not at quarter turn");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##TOTAL_LAT done)
        else $error("result missing after fixed latency");

endmodule

@@ bench/tb_quaternion_to_euler_top.sv @@
module tb_quaternion_to_euler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int N_RANDOM = 1200;
    localparam int TAIL_CYCLES = STAGES + 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    class attitude_board;
        angles_t angle_q[$];
        longint unsigned atan_tab[24];

        function new();
            atan_tab = '{
                64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        endfunction

        function logic [15:0] vec_angle(longint sy, longint sx);
            logic [31:0] acc;
            longint xs;
            longint ys;
            acc = 32'h0;
            if (sx == 0 && sy == 0)
                return 16'h0;
            if (sx < 0)
            begin
                sx = -sx;
                sy = -sy;
                acc = 32'h80000000;
            end
            for (int i = 0; i < STAGES && i < 24; i++)
            begin
                xs = sx >>> i;
                ys = sy >>> i;
                if (sy >= 0)
                begin
                    sx = sx + ys;
                    sy = sy - xs;
                    acc = acc + atan_tab[i][31:0];
                end
                else
                begin
                    sx = sx - ys;
                    sy = sy + xs;
                    acc = acc - atan_tab[i][31:0];
                end
            end
            acc = acc + 32'h8000;
            return acc[31:16];
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                                logic signed [15:0] qy, logic signed [15:0] qz);
            longint w;
            longint x;
            longint y;
            longint z;
            longint one;
            longint sp;
            longint pr;
            longint unsigned rem;
            logic [15:0] a;
            angles_t e;
            w = qw;
            x = qx;
            y = qy;
            z = qz;
            one = 64'sd1 << 30;
            sp = 2 * (w * y - z * x);
            e.clamped = 1'b0;
            if (sp >= one)
            begin
                e.pitch = 16'sd16384;
                e.clamped = 1'b1;
            end
            else if (sp <= -one)
            begin
                e.pitch = -16'sd16384;
                e.clamped = 1'b1;
            end
            else
            begin
                rem = longint'(one * one) - longint'(sp * sp);
                a = vec_angle(sp, longint'(int_sqrt(rem)));
                pr = longint'(signed'(a));
                if (pr > 16384)
                    pr = 16384;
                if (pr < -16384)
                    pr = -16384;
                e.pitch = pr[15:0];
            end
            e.roll = vec_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y));
            e.yaw = vec_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z));
            angle_q.push_back(e);
        endfunction

        // Returns an empty string on a match, else a description.
        function string check_angles(angles_t got);
            angles_t e;
            if (angle_q.size() == 0)
                return $sformatf("unexpected result roll=%0d pitch=%0d yaw=%0d",
                                 got.roll, got.pitch, got.yaw);
            e = angle_q.pop_front();
            if (got.roll !== e.roll || got.pitch !== e.pitch || got.yaw !== e.yaw
                || got.clamped !== e.clamped)
                return $sformatf("got r/p/y/c %0d/%0d/%0d/%0b, want %0d/%0d/%0d/%0b",
                                 got.roll, got.pitch, got.yaw, got.clamped,
                                 e.roll, e.pitch, e.yaw, e.clamped);
            return "";
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic done;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic pitch_clamped;

    attitude_board board;
    int err_count;
    int cycle_count;
    int burst_left;

    quaternion_to_euler_top #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    always #5 clk = ~clk;

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Note each accepted transaction and check each result strobe.
    always @(posedge clk)
    begin
        angles_t got;
        string msg;
        if (rst_n && start && !busy)
            board.note_quat(quat_w, quat_x, quat_y, quat_z);
        if (rst_n && done)
        begin
            got.roll = roll_angle;
            got.pitch = pitch_angle;
            got.yaw = yaw_angle;
            got.clamped = pitch_clamped;
            msg = board.check_angles(got);
            if (msg != "")
                report(msg);
        end
    end

    // Drive one transaction, inserting a random gap between bursts.
    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic signed [15:0] a;
        logic signed [15:0] b;
        int sel;
        sel = $urandom_range(0, 3);
        a = 16'($urandom_range(23100, 23240));
        b = 16'($urandom_range(0, 200));
        case (sel)
            0: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            // near gimbal lock, both signs of pitch
            1: send_quat($urandom_range(0, 1) ? a : -a, b - 16'sd100,
                         $urandom_range(0, 1) ? a : -a, 16'sd100 - b);
            default: send_quat(16'($urandom_range(0, 32767)) - 16'sd16384,
                               16'($urandom_range(0, 32767)) - 16'sd16384,
                               16'($urandom_range(0, 32767)) - 16'sd16384,
                               16'($urandom_range(0, 32767)) - 16'sd16384);
        endcase
    endtask

    initial
    begin
        int waited;
        board = new();
        err_count = 0;
        cycle_count = 0;
        burst_left = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        // pitch sine just below and beyond one in both directions
        send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);
        send_quat(16'sd23171, 16'sd0, 16'sd23171, 16'sd0);
        send_quat(16'sd23171, 16'sd0, -16'sd23171, 16'sd0);
        send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);
        send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd0, 16'sd32767, 16'sd0, -16'sd32767);
        // zero vectors for roll and yaw
        send_quat(16'sd0, 16'sd16384, 16'sd16384, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);
        // negative x axis, small sine of either sign
        send_quat(16'sd1, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(-16'sd1, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd1);
        send_quat(16'sd0, 16'sd32767, 16'sd0, -16'sd1);
        send_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0);

        repeat (N_RANDOM) send_random();
        start <= 1'b0;

        waited = 0;
        while (board.angle_q.size() != 0 && waited < 10 * TAIL_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.angle_q.size() != 0)
            report($sformatf("%0d results never arrived", board.angle_q.size()));
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
